/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/pttn_pkg.sv */
// ----------------------------------------------------------------------------
// Pinyin tone-mark converter package
// Sizes, mark code table and the command passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package pttn_pkg;

    localparam int OUT_LIMIT  = 32;
    localparam int LETTER_MAX = OUT_LIMIT - 2;
    localparam int LCNT_W     = $clog2(OUT_LIMIT);
    localparam int NUM_CODES  = 25;

    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [2:0] TONE_NONE  = 3'd0;
    localparam logic [2:0] TONE_NEUT  = 3'd5;

    localparam logic [15:0] MARK_CODE [NUM_CODES] = '{
        16'hC481, 16'hC493, 16'hC4AB, 16'hC58D, 16'hC5AB, 16'hC796,
        16'hC3A1, 16'hC3A9, 16'hC3AD, 16'hC3B3, 16'hC3BA, 16'hC798,
        16'hC78E, 16'hC49B, 16'hC790, 16'hC792, 16'hC794, 16'hC79A,
        16'hC3A0, 16'hC3A8, 16'hC3AC, 16'hC3B2, 16'hC3B9, 16'hC79C,
        16'hC3BC
    };

    localparam logic [7:0] MARK_LETTER [NUM_CODES] = '{
        "a", "e", "i", "o", "u", "v",
        "a", "e", "i", "o", "u", "v",
        "a", "e", "i", "o", "u", "v",
        "a", "e", "i", "o", "u", "v",
        "v"
    };

    localparam logic [2:0] MARK_TONE [NUM_CODES] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        TONE_NONE
    };

    typedef struct packed {
        logic       hit;
        logic [7:0] letter;
        logic [2:0] tone;
    } mark_t;

    // Bytes one input item gives, in emission order.
    typedef struct packed {
        logic       l0_v;
        logic [7:0] l0;
        logic       l1_v;
        logic [7:0] l1;
        logic       tone_v;
        logic [7:0] tone_byte;
        logic       fin;
    } entry_t;

    function automatic mark_t mark_lookup(input logic [15:0] code);
        mark_t res;
        res = '0;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            if (MARK_CODE[i] == code)
            begin
                res.hit    = 1'b1;
                res.letter = MARK_LETTER[i];
                res.tone   = MARK_TONE[i];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pinyin_tone_mark_to_number.sv */
// ----------------------------------------------------------------------------
// Pinyin tone-mark to tone-number converter
// Rewrites UTF-8 tone-marked vowels as plain letters and appends the tone.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | in_byte[7:0], word_end
// out     | out_valid/out_ready| out_byte[7:0], out_last
//
// One input byte is accepted per cycle while the command queue has room; the
// back end sends output bytes one at a time. Items giving several bytes
// (unmatched held lead, tone digit, terminator) occupy the back end until each
// byte is sent; the two-entry command queue absorbs this.
// Reset returns the word state to idle and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pinyin_tone_mark_to_number (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       word_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import pttn_pkg::*;

    entry_t push_entry;
    entry_t head;
    logic   push, pop, not_empty, not_full;

    pttn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .word_end   (word_end),
        .q_not_full (not_full),
        .q_push     (push),
        .q_entry    (push_entry)
    );

    pttn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .not_full   (not_full)
    );

    pttn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_entry   (head),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

/* hw/rtl/pttn_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts input bytes, pairs lead bytes with the next byte, tracks tone and
// letter count, and issues at most one command per accepted byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pttn_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            word_end,
    input  wire logic            q_not_full,
    output logic                 q_push,
    output pttn_pkg::entry_t     q_entry
);
    import pttn_pkg::*;

    logic              lead_pending_reg, lead_pending_next;
    logic [7:0]        lead_byte_reg, lead_byte_next;
    logic [2:0]        tone_reg, tone_next;
    logic [LCNT_W-1:0] letters_reg, letters_next;

    mark_t             look;
    logic              accept;
    logic              room0, room1;
    logic              emit0, emit1, consumed, hold;
    logic [LCNT_W-1:0] letters1;
    logic [2:0]        tone1;

    always_comb
    begin
        look     = mark_lookup({lead_byte_reg, in_byte});
        room0    = letters_reg < LCNT_W'(LETTER_MAX);
        consumed = lead_pending_reg && look.hit;
        emit0    = lead_pending_reg && room0;
        letters1 = letters_reg + LCNT_W'(emit0);
        room1    = letters1 < LCNT_W'(LETTER_MAX);
        hold     = !consumed && (in_byte >= LEAD_MIN) && !word_end && room1;
        emit1    = !consumed && !hold && room1;
        tone1    = (consumed && room0 && (look.tone != TONE_NONE)) ? look.tone : tone_reg;

        q_entry.l0_v      = emit0;
        q_entry.l0        = consumed ? look.letter : lead_byte_reg;
        q_entry.l1_v      = emit1;
        q_entry.l1        = in_byte;
        q_entry.tone_v    = word_end && (tone1 != TONE_NONE) && (tone1 != TONE_NEUT);
        q_entry.tone_byte = DIGIT_ZERO + {5'd0, tone1};
        q_entry.fin       = word_end;
    end

    assign in_ready = q_not_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (emit0 || emit1 || word_end);

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        tone_next         = tone_reg;
        letters_next      = letters_reg;
        if (accept)
        begin
            if (word_end)
            begin
                // word done: back to the idle state
                lead_pending_next = 1'b0;
                lead_byte_next    = 8'h00;
                tone_next         = TONE_NEUT;
                letters_next      = '0;
            end
            else
            begin
                lead_pending_next = hold;
                if (hold)
                    lead_byte_next = in_byte;
                tone_next    = tone1;
                letters_next = letters1 + LCNT_W'(emit1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
            tone_reg         <= TONE_NEUT;
            letters_reg      <= '0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            tone_reg         <= tone_next;
            letters_reg      <= letters_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pttn_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pttn_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pttn_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output pttn_pkg::entry_t       head,
    output logic                   not_empty,
    output logic                   not_full
);
    import pttn_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != 2'd0;
    assign not_full  = count_reg != 2'd2;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pttn_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Unpacks queued commands into single output bytes behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pttn_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire pttn_pkg::entry_t  q_entry,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);
    import pttn_pkg::*;

    entry_t     cur_reg;
    logic [3:0] mask_reg, mask_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic [3:0] sel;
    logic       advance, issue, last_one;
    logic [7:0] sel_byte;

    always_comb
    begin
        sel      = mask_reg & (~mask_reg + 4'd1);
        advance  = !out_valid_reg || out_ready;
        issue    = advance && (mask_reg != 4'd0);
        last_one = (mask_reg & (mask_reg - 4'd1)) == 4'd0;
        // refill as the final byte of the current command leaves
        q_pop    = q_valid && last_one && ((mask_reg == 4'd0) || advance);

        unique case (sel)
            4'b0001: sel_byte = cur_reg.l0;
            4'b0010: sel_byte = cur_reg.l1;
            4'b0100: sel_byte = cur_reg.tone_byte;
            default: sel_byte = 8'h00;
        endcase

        if (q_pop)
            mask_next = {q_entry.fin, q_entry.tone_v, q_entry.l1_v, q_entry.l0_v};
        else if (issue)
            mask_next = mask_reg & ~sel;
        else
            mask_next = mask_reg;

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = issue;
            out_byte_next  = sel_byte;
            out_last_next  = sel[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_entry;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/pttn_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the converter's ports for output protocol and framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pttn_props (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // hold a stalled result
    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last), "stalled output changed")

    `ASSERT_CLK(a_last_zero, out_valid && out_last |-> out_byte == 8'h00, "terminator is not a zero byte")

    `ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid during reset")

    // a word terminator cannot appear out of an empty pipeline
    `ASSERT_CLK(a_no_early_last, $past(!rst_n) |-> !(out_valid && out_last), "terminator straight after reset")

endmodule

bind pinyin_tone_mark_to_number pttn_props u_pttn_props (.*);

`default_nettype wire
